// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEQ_CAPACITY   = 64;
  localparam int DEQ_WORD_BITS  = 32;
  localparam int DEQ_COUNT_BITS = $clog2(DEQ_CAPACITY + 1);
  localparam int DEQ_DATA_W     = 32;
  localparam int DEQ_KIND_W     = 3;
  localparam int DEQ_STATUS_W   = 2;

  typedef enum logic [DEQ_KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_t;

  typedef enum logic [DEQ_STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

endpackage

// ===== rtl/deq_req_if.sv =====
// Request channel: operation kind and push word.
`timescale 1ns / 1ps

interface deq_req_if
  import deq_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [DEQ_KIND_W-1:0] kind;
  logic [DEQ_DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
// Response channel: status, popped word, count and end words.
`timescale 1ns / 1ps

interface deq_rsp_if
  import deq_pkg::*;
#(
  parameter int COUNT_BITS = DEQ_COUNT_BITS
);
  logic                    valid;
  logic                    ready;
  logic [DEQ_STATUS_W-1:0] status;
  logic [DEQ_DATA_W-1:0]   popped_value;
  logic [COUNT_BITS-1:0]   item_count;
  logic [DEQ_DATA_W-1:0]   front_value;
  logic [DEQ_DATA_W-1:0]   back_value;

  modport source (output valid, output status, output popped_value, output item_count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input popped_value, input item_count,
                  input front_value, input back_value, output ready);
endinterface

// ===== rtl/deq_ring_ram.sv =====
// Ring storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module deq_ring_ram
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEQ_CAPACITY,
  parameter int WIDTH     = DEQ_WORD_BITS,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr0,
  input  logic [ADDR_BITS-1:0] rd_addr1,
  output logic [WIDTH-1:0]     rd_data0,
  output logic [WIDTH-1:0]     rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-cycle write is forwarded by the caller
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit (ring buffer with head index and count).
`timescale 1ns / 1ps
//
// Usage:
//   req  - one word per request: kind (push front, push back, pop front, pop back,
//          clear) and the word to push. Unused kinds leave the queue as is.
//   rsp  - exactly one word per request: status (ok / empty / full), the popped
//          word, the count after the request and the words then at both ends
//          (zero while the queue is empty).
// Timing:
//   A request is taken in the idle state; the ring is updated at that edge and
//   both end slots are read from the registered read ports of the ring RAM. In the
//   load state that follows, the read data is in and the response register is
//   loaded as soon as it is free; the response is then valid and is taken when
//   the sink is ready.
// Stall:
//   The response register holds its word until taken. A new request is taken
//   while it waits, but the next response waits in the load state for it.
// Reset:
//   rst (synchronous) empties the queue: count and head index go to zero. Ring
//   contents are not cleared; slots outside the occupied span are never used.

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int CAPACITY  = DEQ_CAPACITY,
  parameter int WORD_BITS = DEQ_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int SUM_BITS = IDX_BITS + 1;

  // Control state
  state_t              state;
  logic [IDX_BITS-1:0] front;
  logic [CNT_BITS-1:0] count;

  // Per-request results waiting for the read data
  status_t              status_p;
  logic [DEQ_DATA_W-1:0] popped_p;
  logic [CNT_BITS-1:0]  count_p;
  logic                 fwd_front;
  logic                 fwd_back;
  logic [WORD_BITS-1:0] fwd_word;

  // Next values computed at acceptance
  logic [IDX_BITS-1:0]  front_next;
  logic [CNT_BITS-1:0]  count_next;
  status_t              status_next;
  logic [DEQ_DATA_W-1:0] popped_next;

  logic                 accept;
  logic                 load;
  logic                 full;
  logic                 empty;
  logic [IDX_BITS-1:0]  front_dec;
  logic [IDX_BITS-1:0]  front_inc;
  logic [IDX_BITS-1:0]  tail_pos;

  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [IDX_BITS-1:0]  rd_addr0;
  logic [IDX_BITS-1:0]  rd_addr1;
  logic [WORD_BITS-1:0] rd_data0;
  logic [WORD_BITS-1:0] rd_data1;
  logic [63:0]          push_wide;
  logic [63:0]          front_wide;
  logic [63:0]          back_wide;

  // Wrap a position that is below twice the capacity back into the ring.
  function automatic logic [IDX_BITS-1:0] ring_wrap(input logic [SUM_BITS-1:0] pos);
    logic [SUM_BITS-1:0] r;
    r = (pos >= SUM_BITS'(CAPACITY)) ? pos - SUM_BITS'(CAPACITY) : pos;
    return r[IDX_BITS-1:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_LOAD) && (!rsp.valid || rsp.ready);

  assign full      = (count == CNT_BITS'(CAPACITY));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? IDX_BITS'(CAPACITY - 1) : front - IDX_BITS'(1);
  assign front_inc = (front == IDX_BITS'(CAPACITY - 1)) ? '0 : front + IDX_BITS'(1);
  assign tail_pos  = ring_wrap(SUM_BITS'(front) + SUM_BITS'(count));

  // Only the low WORD_BITS of the push word are kept.
  assign push_wide = 64'(req.push_value);
  assign wr_data   = push_wide[WORD_BITS-1:0];

  // Request decode. Pops take the popped word from the end words held in the
  // response register, which always mirror the current ends of the ring.
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = STATUS_OK;
    popped_next = '0;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    case (kind_t'(req.kind))
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + CNT_BITS'(1);
          wr_en      = accept;
          wr_addr    = front_dec;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + CNT_BITS'(1);
          wr_en      = accept;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          popped_next = rsp.front_value;
          front_next  = front_inc;
          count_next  = count - CNT_BITS'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          popped_next = rsp.back_value;
          count_next  = count - CNT_BITS'(1);
        end
      end
      KIND_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // End slots after the request; the back address is unused when empty.
  assign rd_addr0 = front_next;
  assign rd_addr1 = (count_next == '0) ? front_next :
                    ring_wrap(SUM_BITS'(front_next) + SUM_BITS'(count_next) - SUM_BITS'(1));

  deq_ring_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
            front <= front_next;
            count <= count_next;
          end
        end
        S_LOAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pending results and write forwarding (the RAM reads before it writes)
  always_ff @(posedge clk) begin
    if (accept) begin
      status_p  <= status_next;
      popped_p  <= popped_next;
      count_p   <= count_next;
      fwd_front <= wr_en && (wr_addr == rd_addr0);
      fwd_back  <= wr_en && (wr_addr == rd_addr1);
      fwd_word  <= wr_data;
    end
  end

  assign front_wide = 64'(fwd_front ? fwd_word : rd_data0);
  assign back_wide  = 64'(fwd_back ? fwd_word : rd_data1);

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status       <= status_p;
      rsp.popped_value <= popped_p;
      rsp.item_count   <= count_p;
      rsp.front_value  <= (count_p == '0) ? '0 : front_wide[DEQ_DATA_W-1:0];
      rsp.back_value   <= (count_p == '0) ? '0 : back_wide[DEQ_DATA_W-1:0];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("stored count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STATUS_FULL) |-> rsp.item_count == CNT_BITS'(CAPACITY))
    else $error("full status with room left");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.item_count == '0) |-> (rsp.front_value == '0) && (rsp.back_value == '0))
    else $error("end words not zero on empty queue");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD) && (count == $past(count_next)))
    else $error("request not carried into load state");

endmodule
